@@ design/zscore_normalized_histogram_defines.svh @@
// Assertion macros for the z-score histogram block.
`ifndef ZSCORE_NORMALIZED_HISTOGRAM_DEFINES_SVH
`define ZSCORE_NORMALIZED_HISTOGRAM_DEFINES_SVH
`ifndef ASSERT_OFF
// Check that holds at every clock edge outside reset
`define ZSH_ASSERT(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) cond) \
		else $error("zsh assertion failed");
// Check on the cycle after a condition
`define ZSH_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("zsh assertion failed");
`else
`define ZSH_ASSERT(label, cond)
`define ZSH_ASSERT_NEXT(label, pre, post)
`endif
`endif

@@ design/zsh_pkg.sv @@
// Shared constants, types and state codes of the z-score histogram block.
package zsh_pkg;

	localparam int MAX_SAMPLES = 4096;
	localparam int MAX_BINS    = 64;
	localparam int DIV_STEPS   = 64;
	localparam int SQRT_STEPS  = 32;

	// Register indexes
	localparam logic [1:0] REG_BIN_COUNT  = 2'd0;
	localparam logic [1:0] REG_RANGE_LOW  = 2'd1;
	localparam logic [1:0] REG_RANGE_HIGH = 2'd2;

	// Register reset values (+/-3.0 in Q8.16)
	localparam logic [6:0]  RST_BIN_COUNT  = 7'd64;
	localparam logic [23:0] RST_RANGE_LOW  = 24'hFD0000;
	localparam logic [23:0] RST_RANGE_HIGH = 24'h030000;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_MEAN,
		ST_MEAN_W,
		ST_SQ_RD,
		ST_SQ_D,
		ST_SQ_MUL,
		ST_SQ_ACC,
		ST_VAR,
		ST_VAR_W,
		ST_SQRT,
		ST_SEL,
		ST_ZB_DIV,
		ST_ZB_W,
		ST_Z_RD,
		ST_Z_D,
		ST_Z_DIV,
		ST_Z_DIV_W,
		ST_Z_CMP,
		ST_Z_BDIV,
		ST_Z_BDIV_W,
		ST_Z_BRD,
		ST_Z_BWR,
		ST_E_RD,
		ST_E_LD,
		ST_E_WAIT
	} state_t;

	typedef struct packed {
		logic        start;
		logic [63:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quotient;
	} div_rsp_t;

endpackage

@@ design/zsh_div.sv @@
// Shared unsigned 64 by 32 bit restoring divider, one quotient bit a cycle.
module zsh_div (
	input  logic              clk,
	input  logic              arst_n,
	input  zsh_pkg::div_req_t req,
	output zsh_pkg::div_rsp_t rsp
);

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [63:0] quot_q;
	logic [31:0] rem_q;
	logic [31:0] dsr_q;
	logic [32:0] shifted;
	logic [32:0] diff;
	logic        ge;

	// One trial subtract per cycle
	assign shifted = {rem_q, quot_q[63]};
	assign ge      = shifted >= {1'b0, dsr_q};
	assign diff    = shifted - {1'b0, dsr_q};

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(zsh_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			quot_q <= req.dividend;
			rem_q  <= '0;
			dsr_q  <= req.divisor;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[31:0] : shifted[31:0];
			quot_q <= {quot_q[62:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quot_q;

endmodule

@@ design/zscore_normalized_histogram.sv @@
// Top level of the z-score normalized histogram block.
//
//  channel  direction  handshake          words
//  in       input      in_valid/in_stall  sample_value, last_sample
//  out      output     out_valid/out_stall bin_index, bin_total, last_bin
//  apb      input      psel/penable       bin_count_used, range_low, range_high
//
// Samples are taken one per cycle into the sample memory while idle.
// The word with last_sample starts the pass: a divide for the mean, the squared
// deviation of every sample, a divide for the variance and the square root, then
// per sample a z-score divide and, inside the range, a second one for the bin
// (both on the shared divider). Bins leave one at a time as out_stall allows.
// in_stall is high from the last word until the last bin is taken; reset clears control state.
`include "zscore_normalized_histogram_defines.svh"

module zscore_normalized_histogram (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] sample_value,
	input  logic        last_sample,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  bin_index,
	output logic [12:0] bin_total,
	output logic        last_bin,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	zsh_pkg::state_t st_q, st_d;

	logic [6:0]         bcu_q;
	logic signed [23:0] lo_q, hi_q;
	logic [12:0]        held_q;
	logic [44:0]        sum_q;
	logic [11:0]        idx_q;
	logic [5:0]         k_q;
	logic [zsh_pkg::MAX_BINS-1:0] vld_q;

	logic [31:0] store_mem [zsh_pkg::MAX_SAMPLES];
	logic [31:0] store_rd_q;
	logic [12:0] bin_mem [zsh_pkg::MAX_BINS];
	logic [12:0] bin_rd_q;

	logic signed [32:0] mean_q;
	logic signed [33:0] d_q;
	logic [49:0]        sqp_q;
	logic [63:0]        sqsum_q;
	logic [63:0]        sq_x_q;
	logic [33:0]        sq_rem_q;
	logic [31:0]        sq_root_q;
	logic [4:0]         sq_cnt_q;
	logic signed [50:0] z_q;
	logic [30:0]        bprod_q;
	logic [5:0]         bsel_q;

	logic        out_valid_q;
	logic [5:0]  bin_index_q;
	logic [12:0] bin_total_q;
	logic        last_bin_q;

	zsh_pkg::div_req_t div_req;
	zsh_pkg::div_rsp_t div_rsp;

	logic               in_acc, cfg_wr, store_ok, last_idx;
	logic [6:0]         nb;
	logic signed [24:0] w;
	logic               w_pos;
	logic [44:0]        abs_sum;
	logic signed [33:0] d_now;
	logic [33:0]        abs_d;
	logic [32:0]        ud;
	logic [65:0]        sq_full;
	logic [23:0]        abs_lo;
	logic signed [50:0] lo51, hi51, t51;
	logic               z_in;
	logic [35:0]        sq_r2, sq_trial;
	logic               sq_ge;
	logic               zb_ok;
	logic [5:0]         bclamp;
	logic               bin_we;
	logic [5:0]         bin_wa, bin_ra;
	logic [12:0]        bin_wd;

	zsh_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Handshake and register decode
	assign in_acc   = in_valid && !in_stall;
	assign cfg_wr   = psel && penable && pwrite;
	assign pready   = 1'b1;
	assign store_ok = held_q < 13'(zsh_pkg::MAX_SAMPLES);
	assign last_idx = idx_q == 12'(held_q - 13'd1);

	always_comb begin
		unique case (paddr[3:2])
			zsh_pkg::REG_BIN_COUNT:  prdata = {25'd0, bcu_q};
			zsh_pkg::REG_RANGE_LOW:  prdata = {{8{lo_q[23]}}, lo_q};
			zsh_pkg::REG_RANGE_HIGH: prdata = {{8{hi_q[23]}}, hi_q};
			default:                 prdata = '0;
		endcase
	end

	// Bins in use, range width
	assign nb = (bcu_q == 7'd0) ? 7'd1 :
		(bcu_q > 7'(zsh_pkg::MAX_BINS)) ? 7'(zsh_pkg::MAX_BINS) : bcu_q;
	assign w     = {hi_q[23], hi_q} - {lo_q[23], lo_q};
	assign w_pos = !w[24] && (w != 25'sd0);

	// Deviation and its square
	assign abs_sum = sum_q[44] ? 45'(-sum_q) : sum_q;
	assign d_now   = {{2{store_rd_q[31]}}, store_rd_q} - {mean_q[32], mean_q};
	assign abs_d   = d_q[33] ? 34'(-d_q) : d_q;
	assign ud      = abs_d[32:0];
	assign sq_full = 66'(ud) * 66'(ud);

	// Range checks on the z-score
	assign abs_lo = lo_q[23] ? 24'(-lo_q) : lo_q;
	assign lo51   = {{27{lo_q[23]}}, lo_q};
	assign hi51   = {{27{hi_q[23]}}, hi_q};
	assign z_in   = (z_q >= lo51) && (z_q < hi51);
	assign t51    = z_q - lo51;
	assign zb_ok  = lo_q[23] || (lo_q == 24'sd0) ?
		(div_rsp.quotient < 64'(nb)) : (div_rsp.quotient == 64'd0);
	assign bclamp = (div_rsp.quotient >= 64'(nb)) ? 6'(nb - 7'd1) : div_rsp.quotient[5:0];

	// Square root digit step
	assign sq_r2    = {sq_rem_q, sq_x_q[63:62]};
	assign sq_trial = {2'b00, sq_root_q, 2'b01};
	assign sq_ge    = sq_r2 >= sq_trial;

	// Next state and control outputs
	always_comb begin
		st_d             = st_q;
		in_stall         = st_q != zsh_pkg::ST_IDLE;
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = '0;
		bin_we           = 1'b0;
		bin_wa           = bsel_q;
		bin_wd           = '0;
		bin_ra           = (st_q == zsh_pkg::ST_E_RD) ? k_q : bsel_q;
		unique case (st_q)
			zsh_pkg::ST_IDLE: begin
				if (in_acc && last_sample) st_d = zsh_pkg::ST_MEAN;
			end
			zsh_pkg::ST_MEAN: begin
				div_req.start    = 1'b1;
				div_req.dividend = 64'(abs_sum);
				div_req.divisor  = 32'(held_q);
				st_d             = zsh_pkg::ST_MEAN_W;
			end
			zsh_pkg::ST_MEAN_W: begin
				if (div_rsp.done) st_d = zsh_pkg::ST_SQ_RD;
			end
			zsh_pkg::ST_SQ_RD:  st_d = zsh_pkg::ST_SQ_D;
			zsh_pkg::ST_SQ_D:   st_d = zsh_pkg::ST_SQ_MUL;
			zsh_pkg::ST_SQ_MUL: st_d = zsh_pkg::ST_SQ_ACC;
			zsh_pkg::ST_SQ_ACC: begin
				st_d = last_idx ? zsh_pkg::ST_VAR : zsh_pkg::ST_SQ_RD;
			end
			zsh_pkg::ST_VAR: begin
				if (held_q > 13'd1) begin
					div_req.start    = 1'b1;
					div_req.dividend = sqsum_q;
					div_req.divisor  = 32'(held_q);
					st_d             = zsh_pkg::ST_VAR_W;
				end else begin
					st_d = zsh_pkg::ST_SQRT;
				end
			end
			zsh_pkg::ST_VAR_W: begin
				if (div_rsp.done) st_d = zsh_pkg::ST_SQRT;
			end
			zsh_pkg::ST_SQRT: begin
				if (sq_cnt_q == 5'(zsh_pkg::SQRT_STEPS - 1)) st_d = zsh_pkg::ST_SEL;
			end
			zsh_pkg::ST_SEL: begin
				if (!w_pos) st_d = zsh_pkg::ST_E_RD;
				else if (sq_root_q != 32'd0) st_d = zsh_pkg::ST_Z_RD;
				else st_d = zsh_pkg::ST_ZB_DIV;
			end
			zsh_pkg::ST_ZB_DIV: begin
				div_req.start    = 1'b1;
				div_req.dividend = 64'(bprod_q);
				div_req.divisor  = 32'(w);
				st_d             = zsh_pkg::ST_ZB_W;
			end
			zsh_pkg::ST_ZB_W: begin
				if (div_rsp.done) begin
					bin_we = zb_ok;
					bin_wa = div_rsp.quotient[5:0];
					bin_wd = held_q;
					st_d   = zsh_pkg::ST_E_RD;
				end
			end
			zsh_pkg::ST_Z_RD: st_d = zsh_pkg::ST_Z_D;
			zsh_pkg::ST_Z_D:  st_d = zsh_pkg::ST_Z_DIV;
			zsh_pkg::ST_Z_DIV: begin
				div_req.start    = 1'b1;
				div_req.dividend = 64'({ud, 16'd0});
				div_req.divisor  = sq_root_q;
				st_d             = zsh_pkg::ST_Z_DIV_W;
			end
			zsh_pkg::ST_Z_DIV_W: begin
				if (div_rsp.done) st_d = zsh_pkg::ST_Z_CMP;
			end
			zsh_pkg::ST_Z_CMP: begin
				if (z_in) st_d = zsh_pkg::ST_Z_BDIV;
				else st_d = last_idx ? zsh_pkg::ST_E_RD : zsh_pkg::ST_Z_RD;
			end
			zsh_pkg::ST_Z_BDIV: begin
				div_req.start    = 1'b1;
				div_req.dividend = 64'(bprod_q);
				div_req.divisor  = 32'(w);
				st_d             = zsh_pkg::ST_Z_BDIV_W;
			end
			zsh_pkg::ST_Z_BDIV_W: begin
				if (div_rsp.done) st_d = zsh_pkg::ST_Z_BRD;
			end
			zsh_pkg::ST_Z_BRD: st_d = zsh_pkg::ST_Z_BWR;
			zsh_pkg::ST_Z_BWR: begin
				bin_we = 1'b1;
				bin_wa = bsel_q;
				bin_wd = (vld_q[bsel_q] ? bin_rd_q : 13'd0) + 13'd1;
				st_d   = last_idx ? zsh_pkg::ST_E_RD : zsh_pkg::ST_Z_RD;
			end
			zsh_pkg::ST_E_RD: st_d = zsh_pkg::ST_E_LD;
			zsh_pkg::ST_E_LD: st_d = zsh_pkg::ST_E_WAIT;
			zsh_pkg::ST_E_WAIT: begin
				if (!out_stall) st_d = last_bin_q ? zsh_pkg::ST_IDLE : zsh_pkg::ST_E_RD;
			end
			default: st_d = zsh_pkg::ST_IDLE;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= zsh_pkg::ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcu_q       <= zsh_pkg::RST_BIN_COUNT;
			lo_q        <= zsh_pkg::RST_RANGE_LOW;
			hi_q        <= zsh_pkg::RST_RANGE_HIGH;
			held_q      <= '0;
			sum_q       <= '0;
			idx_q       <= '0;
			k_q         <= '0;
			vld_q       <= '0;
			sq_cnt_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				case (paddr[3:2])
					zsh_pkg::REG_BIN_COUNT:  bcu_q <= pwdata[6:0];
					zsh_pkg::REG_RANGE_LOW:  lo_q  <= pwdata[23:0];
					zsh_pkg::REG_RANGE_HIGH: hi_q  <= pwdata[23:0];
					default: ;
				endcase
			end
			if (bin_we) vld_q[bin_wa] <= 1'b1;
			case (st_q)
				zsh_pkg::ST_IDLE: begin
					if (in_acc && store_ok) begin
						held_q <= held_q + 13'd1;
						sum_q  <= sum_q + {{13{sample_value[31]}}, sample_value};
					end
				end
				zsh_pkg::ST_MEAN: begin
					idx_q <= '0;
					k_q   <= '0;
					vld_q <= '0;
				end
				zsh_pkg::ST_SQ_ACC: begin
					idx_q <= last_idx ? 12'd0 : idx_q + 12'd1;
				end
				zsh_pkg::ST_VAR:  sq_cnt_q <= '0;
				zsh_pkg::ST_SQRT: sq_cnt_q <= sq_cnt_q + 5'd1;
				zsh_pkg::ST_Z_CMP: begin
					if (!z_in) idx_q <= idx_q + 12'd1;
				end
				zsh_pkg::ST_Z_BWR: idx_q <= idx_q + 12'd1;
				zsh_pkg::ST_E_LD:  out_valid_q <= 1'b1;
				zsh_pkg::ST_E_WAIT: begin
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						k_q         <= k_q + 6'd1;
						if (last_bin_q) begin
							held_q <= '0;
							sum_q  <= '0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (st_q)
			zsh_pkg::ST_MEAN: sqsum_q <= '0;
			zsh_pkg::ST_MEAN_W: begin
				mean_q <= sum_q[44] ? 33'(-div_rsp.quotient[32:0]) : div_rsp.quotient[32:0];
			end
			zsh_pkg::ST_SQ_D:   d_q     <= d_now;
			zsh_pkg::ST_SQ_MUL: sqp_q   <= sq_full[65:16];
			zsh_pkg::ST_SQ_ACC: sqsum_q <= sqsum_q + 64'(sqp_q);
			zsh_pkg::ST_VAR: begin
				sq_x_q    <= '0;
				sq_rem_q  <= '0;
				sq_root_q <= '0;
			end
			zsh_pkg::ST_VAR_W: begin
				if (div_rsp.done) sq_x_q <= {div_rsp.quotient[47:0], 16'd0};
			end
			zsh_pkg::ST_SQRT: begin
				sq_rem_q  <= sq_ge ? 34'(sq_r2 - sq_trial) : sq_r2[33:0];
				sq_root_q <= {sq_root_q[30:0], sq_ge};
				sq_x_q    <= {sq_x_q[61:0], 2'b00};
			end
			zsh_pkg::ST_SEL:    bprod_q <= 31'(abs_lo) * 31'(nb);
			zsh_pkg::ST_Z_D:    d_q     <= d_now;
			zsh_pkg::ST_Z_DIV_W: begin
				z_q <= d_q[33] ? 51'(-{2'b00, div_rsp.quotient[48:0]}) :
					{2'b00, div_rsp.quotient[48:0]};
			end
			zsh_pkg::ST_Z_CMP: bprod_q <= 31'(t51[23:0]) * 31'(nb);
			zsh_pkg::ST_Z_BDIV_W: begin
				if (div_rsp.done) bsel_q <= bclamp;
			end
			zsh_pkg::ST_E_LD: begin
				bin_index_q <= k_q;
				bin_total_q <= vld_q[k_q] ? bin_rd_q : 13'd0;
				last_bin_q  <= {1'b0, k_q} == nb - 7'd1;
			end
			default: ;
		endcase
	end

	// Sample memory: write while loading, read at the pass index
	always_ff @(posedge clk) begin
		if (st_q == zsh_pkg::ST_IDLE && in_acc && store_ok) begin
			store_mem[held_q[11:0]] <= sample_value;
		end
		store_rd_q <= store_mem[idx_q];
	end

	// Bin counter memory
	always_ff @(posedge clk) begin
		if (bin_we) bin_mem[bin_wa] <= bin_wd;
		bin_rd_q <= bin_mem[bin_ra];
	end

	assign out_valid = out_valid_q;
	assign bin_index = bin_index_q;
	assign bin_total = bin_total_q;
	assign last_bin  = last_bin_q;

	// Checks
	`ZSH_ASSERT(a_held_max, held_q <= 13'(zsh_pkg::MAX_SAMPLES))
	`ZSH_ASSERT(a_out_in_emit, out_valid_q |-> st_q == zsh_pkg::ST_E_WAIT)
	`ZSH_ASSERT(a_last_index, out_valid_q && last_bin_q |-> {1'b0, bin_index_q} == nb - 7'd1)
	`ZSH_ASSERT_NEXT(a_new_set, out_valid_q && last_bin_q && !out_stall, st_q == zsh_pkg::ST_IDLE && held_q == 13'd0)

endmodule

@@ sim/zsh_histogram_checker.sv @@
// Checker for the z-score histogram block: tracks registers, predicts bins, compares words.
module zsh_histogram_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [31:0] sample_value,
	input  logic        last_sample,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [5:0]  bin_index,
	input  logic [12:0] bin_total,
	input  logic        last_bin,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          mismatches,
	output int          bins_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		bit [5:0]  idx;
		bit [12:0] total;
		bit        last;
	} bin_word_t;

	bin_word_t   expected_bins[$];
	bit [31:0]   set_samples[zsh_pkg::MAX_SAMPLES];
	int          set_count;
	longint      set_sum;
	bit [6:0]    bins_reg;
	bit [23:0]   low_reg;
	bit [23:0]   high_reg;

	assign bins_pending = expected_bins.size();

	// floor(sqrt(x)), bit by bit
	function automatic bit [63:0] int_sqrt(bit [63:0] x);
		bit [63:0] root;
		bit [63:0] one;
		root = 0;
		one = 64'd1 << 62;
		while (one > x)
			one = one >> 2;
		while (one != 0) begin
			if (x >= root + one) begin
				x = x - (root + one);
				root = (root >> 1) + one;
			end else begin
				root = root >> 1;
			end
			one = one >> 2;
		end
		return root;
	endfunction

	// Mean, deviation, z-scores and binning of the held set; queues one word per bin
	function automatic void predict_histogram();
		longint    nb, n, lo, hi, w, mean, d, z, b;
		bit [63:0] ud, sq_sum, var_q, sd;
		int        counts[zsh_pkg::MAX_BINS];
		bin_word_t bw;
		nb = (bins_reg == 0) ? 1 : ((bins_reg > zsh_pkg::MAX_BINS) ?
			zsh_pkg::MAX_BINS : longint'(bins_reg));
		n = set_count;
		lo = longint'(signed'(low_reg));
		hi = longint'(signed'(high_reg));
		w = hi - lo;
		foreach (counts[k])
			counts[k] = 0;
		if (n > 0) begin
			mean = set_sum / n;
			sq_sum = 0;
			for (int i = 0; i < set_count; i++) begin
				d = longint'(signed'(set_samples[i])) - mean;
				ud = (d < 0) ? -d : d;
				sq_sum = sq_sum + ((ud * ud) >> 16);
			end
			var_q = (n > 1) ? sq_sum / n : 0;
			sd = int_sqrt(var_q << 16);
			if (w > 0) begin
				if (sd != 0) begin
					for (int i = 0; i < set_count; i++) begin
						d = longint'(signed'(set_samples[i])) - mean;
						z = (d * 65536) / longint'(sd);
						if (z >= lo && z < hi) begin
							b = ((z - lo) * nb) / w;
							if (b >= nb)
								b = nb - 1;
							counts[b]++;
						end
					end
				end else begin
					// zero deviation: whole set lands in the bin of z = 0
					b = ((0 - lo) * nb) / w;
					if (b >= 0 && b < nb)
						counts[b] = int'(n);
				end
			end
		end
		for (int k = 0; k < nb; k++) begin
			bw.idx = k[5:0];
			bw.total = counts[k][12:0];
			bw.last = (k == nb - 1);
			expected_bins.insert(expected_bins.size(), bw);
		end
	endfunction

	// Register writes, sample capture and result compare
	always @(posedge clk or negedge arst_n) begin
		bin_word_t exp_w;
		if (!arst_n) begin
			bins_reg <= zsh_pkg::RST_BIN_COUNT;
			low_reg <= zsh_pkg::RST_RANGE_LOW;
			high_reg <= zsh_pkg::RST_RANGE_HIGH;
			set_count = 0;
			set_sum = 0;
			mismatches = 0;
			expected_bins.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					zsh_pkg::REG_BIN_COUNT:  bins_reg <= pwdata[6:0];
					zsh_pkg::REG_RANGE_LOW:  low_reg <= pwdata[23:0];
					zsh_pkg::REG_RANGE_HIGH: high_reg <= pwdata[23:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				// words past a full store are dropped but a last flag still counts
				if (set_count < zsh_pkg::MAX_SAMPLES) begin
					set_samples[set_count] = sample_value;
					set_sum = set_sum + longint'(signed'(sample_value));
					set_count++;
				end
				if (last_sample) begin
					predict_histogram();
					set_count = 0;
					set_sum = 0;
				end
			end
			if (out_valid && !out_stall) begin
				if (expected_bins.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected bin word: index %0d total %0d last %0d",
							bin_index, bin_total, last_bin);
				end else begin
					exp_w = expected_bins.pop_front();
					if (bin_index !== exp_w.idx || bin_total !== exp_w.total ||
							last_bin !== exp_w.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("bin mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
								exp_w.idx, exp_w.total, exp_w.last,
								bin_index, bin_total, last_bin);
					end
				end
			end
		end
	end

endmodule

@@ sim/tb.sv @@
// Testbench top: stimulus, register programming and verdict for the z-score histogram.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] REG_SPARE = 2'd3;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int HOLD_CYCLES = 3000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] sample_value;
	logic        last_sample;
	logic        out_valid;
	logic        out_stall;
	logic [5:0]  bin_index;
	logic [12:0] bin_total;
	logic        last_bin;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          mismatches;
	int          bins_pending;
	int          cycles;
	bit          no_gaps;
	bit          hold_request;

	zscore_normalized_histogram i_dut (.*);

	zsh_histogram_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		sample_value = '0;
		last_sample = 1'b0;
		out_stall = 1'b1;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		no_gaps = 1'b0;
		hold_request = 1'b0;
		cycles = 0;
	end

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("zscore_normalized_histogram test failed");
			$finish;
		end
	end

	// Result side: random stall per word, plus one long hold on request
	initial begin
		int w;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
			end
			w = no_gaps ? 0 : $urandom_range(0, 9);
			if (w > 0) begin
				out_stall <= 1'b1;
				repeat (w) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// One register write: setup then access
	task automatic reg_write(logic [1:0] idx, logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Block idle between sets: input withdrawn, every bin taken, then a short settle
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (bins_pending == 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic program_regs(logic [6:0] nb, int lo, int hi);
		wait_idle();
		reg_write(zsh_pkg::REG_BIN_COUNT, {25'd0, nb});
		reg_write(zsh_pkg::REG_RANGE_LOW, lo);
		reg_write(zsh_pkg::REG_RANGE_HIGH, hi);
	endtask

	// Offer one sample word, holding valid across back-to-back words
	task automatic send_word(logic [31:0] value, logic last);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		sample_value <= value;
		last_sample <= last;
		do @(posedge clk); while (in_stall);
	endtask

	// A random set; kind picks the shape of the data
	task automatic send_random_set(int len);
		int        kind;
		logic [31:0] base;
		logic [31:0] v;
		kind = $urandom_range(0, 5);
		base = $urandom;
		for (int i = 0; i < len; i++) begin
			case (kind)
				0: v = $urandom;
				1: v = base;
				2: v = (i == len - 1) ? $urandom : base + $urandom_range(0, 3);
				3: v = $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
				default: v = base + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
			endcase
			send_word(v, i == len - 1);
		end
	endtask

	task automatic random_sets(int words);
		int sent;
		int len;
		sent = 0;
		while (sent < words) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
			send_random_set(len);
			sent += len;
		end
	endtask

	initial begin
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed sets under reset registers
		send_word(32'h7FFFFFFF, 1'b1);
		send_word(32'h80000000, 1'b0);
		send_word(32'h7FFFFFFF, 1'b1);
		repeat (3) send_word(32'h0001_8000, 1'b0);
		send_word(32'h0001_8000, 1'b1);
		send_word(32'h0000_0000, 1'b0);
		send_word(32'h0001_0000, 1'b0);
		send_word(32'hFFFF_0000, 1'b0);
		send_word(32'h0002_0000, 1'b0);
		send_word(32'hFFFE_0000, 1'b0);
		send_word(32'h0030_0000, 1'b0);
		send_word(32'hFFFF_FFFF, 1'b0);
		send_word(32'h0000_0001, 1'b1);

		// Zero-deviation bin out of range, bin count zero, spare register
		program_regs(7'd0, 32'h0001_0000, 32'h0004_0000);
		reg_write(REG_SPARE, 32'hFFFF_FFFF);
		send_word(32'h1234_5678, 1'b1);
		send_word(32'h0000_0005, 1'b0);
		send_word(32'h0020_0000, 1'b1);

		// Degenerate range, oversized bin count
		program_regs(7'd127, 32'h0001_0000, 32'h0001_0000);
		random_sets(20);

		// Widest range, single bin
		program_regs(7'd1, 32'hFF80_0000, 32'h007F_FFFF);
		random_sets(20);

		// Full bins, long hold on the result side while sets keep coming
		program_regs(7'd64, 32'hFFFD_0000, 32'h0003_0000);
		hold_request = 1'b1;
		random_sets(50);

		// Narrow range, odd bin count, no idling either side
		program_regs(7'd37, 32'hFFFF_8000, 32'h0001_4000);
		no_gaps = 1'b1;
		random_sets(40);
		no_gaps = 1'b0;

		// Range above zero, default-like bins
		program_regs(7'd100, 32'h0000_0001, 32'h0002_0000);
		random_sets(40);

		// Reset-like registers, pause for every bin before each set
		program_regs(7'd64, 32'hFFFD_0000, 32'h0003_0000);
		repeat (8) begin
			wait_idle();
			send_random_set($urandom_range(1, 8));
		end
		random_sets(40);

		@(negedge clk);
		in_valid <= 1'b0;
		wait (bins_pending == 0);
		repeat (50) @(posedge clk);
		if (mismatches == 0) begin
			$display("zscore_normalized_histogram test passed");
		end else begin
			$display("zscore_normalized_histogram test failed");
		end
		$finish;
	end

endmodule
